@@ hw/rtl/swv_pkg.sv @@
// ----------------------------------------------------------------------------
// swv_pkg
// Shared constants and state types for the sliding window variance block.
// ----------------------------------------------------------------------------
package swv_pkg;

  // Default sizing
  localparam int MAX_WINDOW_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths
  localparam int CFG_W = 11;
  localparam int VAR_W = 47;

  // Window length after reset
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(5);

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUB,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ hw/rtl/sliding_window_variance.sv @@
// ----------------------------------------------------------------------------
// sliding_window_variance
// Rolling population variance over the last N signed samples.
// ----------------------------------------------------------------------------
// Input channel: sample/restart with in_valid, in_stall. A word is taken when
// in_valid is high and in_stall low. restart starts a new series.
// Config channel: window_length with cfg_valid/cfg_ready; write only while
// idle. A write drops the current series. N = 0 acts as 1.
// Output channel: variance with out_valid, out_stall. One word per sample
// once N samples of the series have arrived, none before.
// Front: per sample a ring read, squares and a sum update, in turn.
// Back: a load, shift-add steps over S1_W multiplier bits, a subtract,
// a divide step per quotient bit over DW bits, and an output step; its
// time per result sets the sustained rate when every sample yields one.
// A two-entry queue lets the front run ahead of the back.
// Reset: window length 5, series and queue empty. The sample ring is not
// cleared; only entries written in the current series are ever read.
// A stalled result holds; the front keeps working until the queue fills.
// ----------------------------------------------------------------------------
module sliding_window_variance #(
  parameter int MAX_WINDOW  = swv_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          restart,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swv_pkg::CFG_W-1:0]     window_length,
  output logic [swv_pkg::VAR_W-1:0]     variance,
  output logic                          out_valid,
  input  logic                          out_stall
);
  import swv_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int S1_W = SAMPLE_BITS + AW;
  localparam int S2_W = 2 * SAMPLE_BITS - 1 + AW;
  localparam int E_W  = S1_W + S2_W + NW;
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  logic                   push, pop, q_valid, q_full;
  logic signed [S1_W-1:0] push_s1;
  logic [S2_W-1:0]        push_s2;
  logic [NW-1:0]          push_n;
  logic [E_W-1:0]         q_data;
  logic [QC_W-1:0]        q_count;

  swv_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cfg_valid    (cfg_valid),
    .window_length(window_length),
    .cfg_ready    (cfg_ready),
    .push         (push),
    .push_s1      (push_s1),
    .push_s2      (push_s2),
    .push_n       (push_n),
    .q_full       (q_full)
  );

  swv_queue #(
    .W    (E_W),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_s1, push_s2, push_n}),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_full   (q_full),
    .q_count  (q_count)
  );

  swv_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_s1     (q_data[E_W-1 -: S1_W]),
    .q_s2     (q_data[NW +: S2_W]),
    .q_n      (q_data[NW-1:0]),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .variance (variance)
  );

  // Queue never overfills
  a_q_count: assert property (@(posedge clk) disable iff (rst)
    q_count <= QC_W'(Q_DEPTH))
    else $error("queue count above depth");

  // Front only pushes into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");

  // Back only pops a queued snapshot
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // One result per snapshot: a taken result is not shown again
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

endmodule

@@ hw/rtl/swv_front.sv @@
// ----------------------------------------------------------------------------
// swv_front
// Takes samples, keeps the sample ring and the exact running sums, and
// queues a sums snapshot whenever the window is full.
// ----------------------------------------------------------------------------
module swv_front #(
  parameter int MAX_WINDOW  = swv_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  input  logic                                   restart,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cfg_valid,
  input  logic [swv_pkg::CFG_W-1:0]              window_length,
  output logic                                   cfg_ready,
  output logic                                   push,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]   push_s1,
  output logic [2*SAMPLE_BITS-1+$clog2(MAX_WINDOW)-1:0]      push_s2,
  output logic [$clog2(MAX_WINDOW+1)-1:0]        push_n,
  input  logic                                   q_full
);
  import swv_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int SQ_W = 2 * SAMPLE_BITS - 1;
  localparam int S1_W = SAMPLE_BITS + AW;
  localparam int S2_W = SQ_W + AW;

  front_state_t state, state_next;

  logic [CFG_W-1:0]              len_reg;
  logic [AW-1:0]                 wp;
  logic [NW-1:0]                 fill;
  logic signed [S1_W-1:0]        s1, s1_next;
  logic [S2_W-1:0]               s2, s2_next;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          remove;
  logic                          emit;
  logic [NW-1:0]                 n_reg;
  logic [SQ_W-1:0]               sq_new;
  logic [SQ_W-1:0]               sq_old;

  logic [SAMPLE_BITS-1:0]        ring [MAX_WINDOW];

  logic                          accept;
  logic [NW-1:0]                 n_eff;
  logic [NW-1:0]                 f0;
  logic                          full_now;
  logic [31:0]                   old_sum;
  logic [AW-1:0]                 old_addr;
  logic signed [2*SAMPLE_BITS-1:0] p_new;
  logic signed [2*SAMPLE_BITS-1:0] p_old;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Effective window: zero acts as one, saturate at the ring depth
  always_comb begin
    if (len_reg == '0) begin
      n_eff = NW'(1);
    end else if (32'(len_reg) > 32'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(len_reg);
    end
  end

  // Slot of the sample that leaves the window
  always_comb begin
    old_sum = 32'(wp) + 32'(MAX_WINDOW) - 32'(n_eff);
    if (old_sum >= 32'(MAX_WINDOW)) begin
      old_sum = old_sum - 32'(MAX_WINDOW);
    end
    old_addr = AW'(old_sum);
  end

  // Fill bookkeeping for the incoming word
  assign f0       = restart ? '0 : fill;
  assign full_now = (f0 >= n_eff);

  // Squares
  assign p_new = x_reg * x_reg;
  assign p_old = rd_data * rd_data;

  // Sums after this sample
  always_comb begin
    s1_next = s1 + {{(S1_W-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
    s2_next = s2 + S2_W'(sq_new) - S2_W'(sq_old);
    if (remove) begin
      s1_next = s1_next - {{(S1_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) state_next = F_SQ;
      end
      F_SQ: state_next = F_UPD;
      F_UPD: begin
        if (!emit || !q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall = 1'b1;
    push     = 1'b0;
    case (state)
      F_IDLE:  in_stall = 1'b0;
      F_SQ:    in_stall = 1'b1;
      F_UPD:   push     = emit && !q_full;
      default: in_stall = 1'b1;
    endcase
  end

  assign push_s1 = s1_next;
  assign push_s2 = s2_next;
  assign push_n  = n_reg;

  // Ring: write the new sample, read the leaving one
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp] <= sample;
      rd_data  <= ring[old_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg  <= sample;
      remove <= full_now;
      emit   <= full_now || ((f0 + NW'(1)) == n_eff);
      n_reg  <= n_eff;
    end
    if (state == F_SQ) begin
      sq_new <= p_new[SQ_W-1:0];
      sq_old <= remove ? p_old[SQ_W-1:0] : '0;
    end
  end

  // Control and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      len_reg <= WINDOW_RESET;
      wp      <= '0;
      fill    <= '0;
      s1      <= '0;
      s2      <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        wp   <= (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + AW'(1);
        fill <= full_now ? f0 : f0 + NW'(1);
        if (restart) begin
          s1 <= '0;
          s2 <= '0;
        end
      end
      if (state == F_UPD && (!emit || !q_full)) begin
        s1 <= s1_next;
        s2 <= s2_next;
      end
      // a new window length drops the current series
      if (cfg_valid) begin
        len_reg <= window_length;
        fill    <= '0;
        s1      <= '0;
        s2      <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/swv_queue.sv @@
// ----------------------------------------------------------------------------
// swv_queue
// Short register queue carrying sums snapshots from front to back.
// ----------------------------------------------------------------------------
module swv_queue #(
  parameter int W     = 8,
  parameter int DEPTH = swv_pkg::Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic                       q_valid,
  output logic [W-1:0]               q_data,
  output logic                       q_full,
  output logic [$clog2(DEPTH+1)-1:0] q_count
);
  import swv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign q_valid = (q_count != '0);
  assign q_full  = (q_count == CW'(DEPTH));
  assign q_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        q_count <= q_count + CW'(1);
      end else if (pop && !push) begin
        q_count <= q_count - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/swv_back.sv @@
// ----------------------------------------------------------------------------
// swv_back
// Turns a sums snapshot into a variance: shift-add products, a subtract,
// then a restoring divide by N*N, one bit per cycle.
// ----------------------------------------------------------------------------
module swv_back #(
  parameter int MAX_WINDOW  = swv_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              q_valid,
  input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]  q_s1,
  input  logic [2*SAMPLE_BITS-1+$clog2(MAX_WINDOW)-1:0]     q_s2,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]                   q_n,
  output logic                                              pop,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic [swv_pkg::VAR_W-1:0]                         variance
);
  import swv_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int S1_W = SAMPLE_BITS + AW;
  localparam int S2_W = 2 * SAMPLE_BITS - 1 + AW;
  localparam int NN_W = 2 * NW;
  localparam int DW   = (S2_W + NW > 2 * S1_W) ? S2_W + NW : 2 * S1_W;
  localparam int CW   = $clog2(DW + 1);

  back_state_t state, state_next;

  logic [DW-1:0]   mc_a, mc_b;
  logic [DW-1:0]   acc_a, acc_b;
  logic [NW-1:0]   mp_n;
  logic [S1_W-1:0] mp_s;
  logic [NN_W-1:0] nn;
  logic [DW-1:0]   dvd;
  logic [NN_W-1:0] rem;
  logic [CW-1:0]   cnt;

  logic [S1_W-1:0] s1_mag;
  logic [NN_W:0]   rem_sh;
  logic            q_bit;

  assign s1_mag = q_s1[S1_W-1] ? S1_W'(-q_s1) : S1_W'(q_s1);

  // One restoring divide step
  assign rem_sh = {rem, dvd[DW-1]};
  assign q_bit  = (rem_sh >= {1'b0, nn});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) state_next = B_MUL;
      end
      B_MUL: begin
        if (cnt == CW'(S1_W - 1)) state_next = B_SUB;
      end
      B_SUB: state_next = B_DIV;
      B_DIV: begin
        if (cnt == CW'(DW - 1)) state_next = B_OUT;
      end
      B_OUT: begin
        if (!out_stall) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state)
      B_IDLE:  pop       = q_valid;
      B_OUT:   out_valid = 1'b1;
      default: pop       = 1'b0;
    endcase
  end

  assign variance = VAR_W'(dvd);

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        mc_a  <= DW'(q_s2);
        mc_b  <= DW'(s1_mag);
        mp_n  <= q_n;
        mp_s  <= s1_mag;
        acc_a <= '0;
        acc_b <= '0;
        nn    <= NN_W'(q_n) * NN_W'(q_n);
        cnt   <= '0;
      end
      B_MUL: begin
        // N*S2 and S1*S1 side by side, one multiplier bit per cycle
        if (mp_n[0]) acc_a <= acc_a + mc_a;
        if (mp_s[0]) acc_b <= acc_b + mc_b;
        mc_a <= mc_a << 1;
        mc_b <= mc_b << 1;
        mp_n <= mp_n >> 1;
        mp_s <= mp_s >> 1;
        cnt  <= (cnt == CW'(S1_W - 1)) ? '0 : cnt + CW'(1);
      end
      B_SUB: begin
        dvd <= (acc_a >= acc_b) ? acc_a - acc_b : '0;
        rem <= '0;
        cnt <= '0;
      end
      B_DIV: begin
        // quotient bits shift in from the bottom
        rem <= q_bit ? NN_W'(rem_sh - {1'b0, nn}) : NN_W'(rem_sh);
        dvd <= {dvd[DW-2:0], q_bit};
        cnt <= cnt + CW'(1);
      end
      default: cnt <= cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
